@@ sv/rmbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmbd_pkg;

    // Largest source width handled, as log2, and the line store sized for it.
    localparam int MAX_WIDTH_LOG2 = 11;
    localparam int LINE_ADDR_W    = MAX_WIDTH_LOG2 - 1;
    localparam int LINE_DEPTH     = 1 << LINE_ADDR_W;

    // Counter, channel and sum widths.
    localparam int COL_W   = MAX_WIDTH_LOG2;
    localparam int ROW_W   = 15;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = CHAN_W + 1;
    localparam int TOTAL_W = CHAN_W + 2;
    localparam int CFG_W   = 4;
    localparam int LANES   = 4;
    localparam int LINE_W  = LANES * SUM_W;

    // Configuration register indexes.
    localparam logic CFG_WIDTH_LOG2  = 1'b0;
    localparam logic CFG_HEIGHT_LOG2 = 1'b1;

    // Control shared by all channel lanes.
    typedef struct packed {
        logic wl_zero;    // one pixel wide: a pixel pairs with itself
        logic hold_load;  // even column: keep the pixel as the left one
        logic s1_load;    // a block completes: take the pair sum
        logic use_above;  // add the stored sum from the row above
        logic out_load;   // move the block total into the output register
    } lane_ctrl_t;

endpackage
`default_nettype wire

@@ sv/rmbd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/rmbd_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmbd_lane (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rmbd_pkg::lane_ctrl_t      ctrl,
    input  wire logic [rmbd_pkg::CHAN_W-1:0] px,
    input  wire logic [rmbd_pkg::SUM_W-1:0]  above,
    output logic      [rmbd_pkg::SUM_W-1:0]  pair,
    output logic      [rmbd_pkg::CHAN_W-1:0] avg
);

    logic [rmbd_pkg::CHAN_W-1:0]  hold_reg;
    logic [rmbd_pkg::SUM_W-1:0]   pair_reg;
    logic [rmbd_pkg::CHAN_W-1:0]  avg_reg;
    logic [rmbd_pkg::TOTAL_W-1:0] total;
    logic [rmbd_pkg::TOTAL_W-1:0] rounded;

    // The left pixel of a pair is held until its right neighbour arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else if (ctrl.hold_load)
        begin
            hold_reg <= px;
        end
    end

    // Horizontal pair sum; a single-column level doubles the pixel.
    always_comb
    begin
        if (ctrl.wl_zero)
        begin
            pair = {px, 1'b0};
        end
        else
        begin
            pair = {1'b0, px} + {1'b0, hold_reg};
        end
    end

    // Block total and rounded average from the registered pair sum.
    // The total is at most 1020, so adding two still fits the total width.
    always_comb
    begin
        if (ctrl.use_above)
        begin
            total = {1'b0, pair_reg} + {1'b0, above};
        end
        else
        begin
            total = {pair_reg, 1'b0};
        end
        rounded = total + rmbd_pkg::TOTAL_W'(2);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            pair_reg <= pair;
        end
        if (ctrl.out_load)
        begin
            avg_reg <= rounded[rmbd_pkg::TOTAL_W-1:2];
        end
    end

    assign avg = avg_reg;

endmodule
`default_nettype wire

@@ sv/rgba8_mipmap_box_downsample_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// RGBA8 2x2 box-filter mipmap reduction.
// Source pixels enter in raster order on the input channel (in_valid, in_stall),
// one per clock unless stalled. Set width_log2 and height_log2 on the configuration
// port while the block is idle; widths above 2048 pixels are taken as 2048.
// A pixel that completes a 2x2 block yields one destination pixel on the output
// channel (out_valid, out_stall) via the middle stage and the output register;
// level_done marks the last destination pixel, after which the counters restart.
// Throughput is one source pixel per cycle when not stalled, set by the
// combinational pair add and at most one line-store access per pixel (written
// on even rows, read on odd rows). Four lanes work side by side, each with its
// own output register. When the receiver stalls, one further completed block is
// taken into the middle stage, then in_stall rises until the output moves on.
// Reset clears the counters, the held left pixel and both valid flags and sets
// both size registers to 1; the line store is not cleared, since each entry is
// written on an even row before the odd row below reads it.
module rgba8_mipmap_box_downsample_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [rmbd_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [rmbd_pkg::CHAN_W-1:0]  red_in,
    input  wire logic [rmbd_pkg::CHAN_W-1:0]  green_in,
    input  wire logic [rmbd_pkg::CHAN_W-1:0]  blue_in,
    input  wire logic [rmbd_pkg::CHAN_W-1:0]  alpha_in,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [rmbd_pkg::CHAN_W-1:0]  red_out,
    output logic      [rmbd_pkg::CHAN_W-1:0]  green_out,
    output logic      [rmbd_pkg::CHAN_W-1:0]  blue_out,
    output logic      [rmbd_pkg::CHAN_W-1:0]  alpha_out,
    output logic                              level_done
);

    logic [rmbd_pkg::CFG_W-1:0] width_log2_reg;
    logic [rmbd_pkg::CFG_W-1:0] height_log2_reg;
    logic [rmbd_pkg::COL_W-1:0] col_reg;
    logic [rmbd_pkg::COL_W-1:0] col_next;
    logic [rmbd_pkg::ROW_W-1:0] row_reg;
    logic [rmbd_pkg::ROW_W-1:0] row_next;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_use_above_reg;
    logic                       s1_done_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_done_reg;

    logic [rmbd_pkg::CFG_W-1:0] wl;
    logic [rmbd_pkg::COL_W:0]   last_col_wide;
    logic [rmbd_pkg::ROW_W:0]   last_row_wide;
    logic                       at_last_col;
    logic                       at_last_row;
    logic                       wl_zero;
    logic                       hl_zero;
    logic                       have_pair;
    logic                       emit;
    logic                       accept;
    logic                       move_out;
    logic                       s1_adv;
    logic                       ram_we;
    logic                       ram_re;
    logic [rmbd_pkg::LINE_ADDR_W-1:0] line_addr;
    logic [rmbd_pkg::LINE_W-1:0]      line_wr;
    logic [rmbd_pkg::LINE_W-1:0]      line_rd;
    rmbd_pkg::lane_ctrl_t             ctrl;
    logic [rmbd_pkg::CHAN_W-1:0]      px    [rmbd_pkg::LANES];
    logic [rmbd_pkg::SUM_W-1:0]       pair  [rmbd_pkg::LANES];
    logic [rmbd_pkg::CHAN_W-1:0]      avg   [rmbd_pkg::LANES];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg  <= rmbd_pkg::CFG_W'(1);
            height_log2_reg <= rmbd_pkg::CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rmbd_pkg::CFG_WIDTH_LOG2:  width_log2_reg  <= cfg_data;
                rmbd_pkg::CFG_HEIGHT_LOG2: height_log2_reg <= cfg_data;
                default:                   width_log2_reg  <= width_log2_reg;
            endcase
        end
    end

    // Position decode for the current pixel.
    always_comb
    begin
        if (width_log2_reg > rmbd_pkg::CFG_W'(rmbd_pkg::MAX_WIDTH_LOG2))
        begin
            wl = rmbd_pkg::CFG_W'(rmbd_pkg::MAX_WIDTH_LOG2);
        end
        else
        begin
            wl = width_log2_reg;
        end
        last_col_wide = ((rmbd_pkg::COL_W + 1)'(1) << wl) - (rmbd_pkg::COL_W + 1)'(1);
        last_row_wide = ((rmbd_pkg::ROW_W + 1)'(1) << height_log2_reg)
                        - (rmbd_pkg::ROW_W + 1)'(1);
        at_last_col = col_reg >= last_col_wide[rmbd_pkg::COL_W-1:0];
        at_last_row = row_reg >= last_row_wide[rmbd_pkg::ROW_W-1:0];
        wl_zero     = (wl == '0);
        hl_zero     = (height_log2_reg == '0);
        have_pair   = wl_zero || col_reg[0];
        emit        = have_pair && (hl_zero || row_reg[0]);
        line_addr   = col_reg[rmbd_pkg::COL_W-1:1];
    end

    // Handshake: the middle stage advances whenever the output can move.
    always_comb
    begin
        move_out = !out_valid_reg || !out_stall;
        s1_adv   = s1_valid_reg && move_out;
        in_stall = s1_valid_reg && !move_out;
        accept   = in_valid && !in_stall;
        ram_we   = accept && have_pair && !hl_zero && !row_reg[0];
        ram_re   = accept && have_pair && !hl_zero && row_reg[0];

        ctrl.wl_zero   = wl_zero;
        ctrl.hold_load = accept && !wl_zero && !col_reg[0];
        ctrl.s1_load   = accept && emit;
        ctrl.use_above = s1_use_above_reg;
        ctrl.out_load  = s1_adv;

        s1_valid_next = ctrl.s1_load || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
    end

    // Column and row counters, wrapping at the end of the level.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + rmbd_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + rmbd_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Flags that travel with a completed block.
    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            s1_use_above_reg <= !hl_zero;
            s1_done_reg      <= at_last_col && at_last_row;
        end
        if (s1_adv)
        begin
            out_done_reg <= s1_done_reg;
        end
    end

    // Channel lanes.
    assign px[0] = red_in;
    assign px[1] = green_in;
    assign px[2] = blue_in;
    assign px[3] = alpha_in;

    for (genvar i = 0; i < rmbd_pkg::LANES; i++)
    begin : g_lane
        rmbd_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .px    (px[i]),
            .above (line_rd[i*rmbd_pkg::SUM_W +: rmbd_pkg::SUM_W]),
            .pair  (pair[i]),
            .avg   (avg[i])
        );
        assign line_wr[i*rmbd_pkg::SUM_W +: rmbd_pkg::SUM_W] = pair[i];
    end

    // Line store of even-row pair sums.
    rmbd_ram #(
        .WIDTH (rmbd_pkg::LINE_W),
        .DEPTH (rmbd_pkg::LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (line_addr),
        .wr_data (line_wr),
        .rd_en   (ram_re),
        .rd_addr (line_addr),
        .rd_data (line_rd)
    );

    // Merged output.
    assign out_valid  = out_valid_reg;
    assign red_out    = avg[0];
    assign green_out  = avg[1];
    assign blue_out   = avg[2];
    assign alpha_out  = avg[3];
    assign level_done = out_done_reg;

endmodule
`default_nettype wire
